[hdl/xer_pkg.sv]
// shared types, character codes and helper functions of the entity reference decoder
package xer_pkg;

  localparam int SCAN_LIMIT_DEF = 64;
  localparam int HELD_DEPTH     = 64;
  localparam int HELD_AW        = 6;
  localparam int CNT_W          = 7;
  localparam int NAME_NUM       = 5;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;

  localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO   = 32'h0000_D800;
  localparam logic [31:0] SURR_HI   = 32'h0000_DFFF;
  localparam logic [31:0] LIM_1BYTE = 32'h0000_0080;
  localparam logic [31:0] LIM_2BYTE = 32'h0000_0800;
  localparam logic [31:0] LIM_3BYTE = 32'h0001_0000;
  localparam logic [7:0]  LEAD_2    = 8'hC0;
  localparam logic [7:0]  LEAD_3    = 8'hE0;
  localparam logic [7:0]  LEAD_4    = 8'hF0;
  localparam logic [7:0]  CONT_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte_a;
    logic [7:0] out_byte_b;
    logic [7:0] out_byte_c;
    logic [7:0] out_byte_d;
    logic [2:0] byte_count;
    logic       run_done;
    logic       string_done;
  } out_item_t;

  // byte classification
  typedef struct packed {
    logic       is_amp;
    logic       is_semi;
    logic       is_hash;
    logic       is_x;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] dig;
  } cls_t;

  typedef struct packed {
    in_item_t item;
    cls_t     cls;
  } front_t;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] b;
  } utf_t;

  function automatic cls_t classify(logic [7:0] c);
    cls_t r;
    logic lo, up;
    r = '0;
    lo = (c >= CH_A_LO) && (c <= CH_F_LO);
    up = (c >= CH_A_UP) && (c <= CH_F_UP);
    r.is_amp  = (c == CH_AMP);
    r.is_semi = (c == CH_SEMI);
    r.is_hash = (c == CH_HASH);
    r.is_x    = (c == CH_X_LO) || (c == CH_X_UP);
    r.dec_ok  = (c >= CH_0) && (c <= CH_9);
    r.hex_ok  = r.dec_ok || lo || up;
    if (r.dec_ok) begin
      r.dig = 4'(c - CH_0);
    end else if (lo) begin
      r.dig = 4'(c - CH_A_LO + 8'd10);
    end else if (up) begin
      r.dig = 4'(c - CH_A_UP + 8'd10);
    end
    return r;
  endfunction

  // named entities: lt gt amp quot apos
  function automatic logic [2:0] name_len(int k);
    logic [2:0] r;
    case (k)
      0, 1:    r = 3'd2;
      2:       r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] name_char(int k, logic [1:0] i);
    logic [31:0] s;
    case (k)
      0:       s = {8'h6C, 8'h74, 8'h00, 8'h00};
      1:       s = {8'h67, 8'h74, 8'h00, 8'h00};
      2:       s = {8'h61, 8'h6D, 8'h70, 8'h00};
      3:       s = {8'h71, 8'h75, 8'h6F, 8'h74};
      default: s = {8'h61, 8'h70, 8'h6F, 8'h73};
    endcase
    return s[31 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] name_out(int k);
    logic [7:0] r;
    case (k)
      0:       r = CH_LT;
      1:       r = CH_GT;
      2:       r = CH_AMP;
      3:       r = CH_QUOT;
      default: r = CH_APOS;
    endcase
    return r;
  endfunction

  function automatic utf_t utf8_encode(logic [31:0] v);
    utf_t r;
    r = '0;
    if (v == '0 || v > CP_MAX || (v >= SURR_LO && v <= SURR_HI)) begin
      r.cnt = 3'd0;
    end else if (v < LIM_1BYTE) begin
      r.cnt  = 3'd1;
      r.b[0] = v[7:0];
    end else if (v < LIM_2BYTE) begin
      r.cnt  = 3'd2;
      r.b[0] = LEAD_2 | {3'b0, v[10:6]};
      r.b[1] = CONT_MARK | {2'b0, v[5:0]};
    end else if (v < LIM_3BYTE) begin
      r.cnt  = 3'd3;
      r.b[0] = LEAD_3 | {4'b0, v[15:12]};
      r.b[1] = CONT_MARK | {2'b0, v[11:6]};
      r.b[2] = CONT_MARK | {2'b0, v[5:0]};
    end else begin
      r.cnt  = 3'd4;
      r.b[0] = LEAD_4 | {5'b0, v[20:18]};
      r.b[1] = CONT_MARK | {2'b0, v[17:12]};
      r.b[2] = CONT_MARK | {2'b0, v[11:6]};
      r.b[3] = CONT_MARK | {2'b0, v[5:0]};
    end
    return r;
  endfunction

endpackage

[hdl/xer_ram.sv]
// generic single-write, single-read ram with registered read data
module xer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/xer_front.sv]
// front end: accepts input items, classifies the byte and queues it for the sequencer
module xer_front (
  input  logic              clk,
  input  logic              rst,
  input  xer_pkg::in_item_t text,
  input  logic              push,
  output logic              full,
  output xer_pkg::front_t   fq,
  output logic              fq_valid,
  input  logic              fq_pop
);
  import xer_pkg::*;

  front_t     slot [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign full     = (cnt == 2'd2);
  assign fq_valid = (cnt != 2'd0);
  assign fq       = slot[rp];
  assign do_push  = push && !full;
  assign do_pop   = fq_pop && fq_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= '{item: text, cls: classify(text.text_byte)};
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

[hdl/xer_back.sv]
// back end: reference sequencer, held byte store, replay, utf-8 output and group packing
module xer_back #(
  parameter int SCAN_LIMIT = xer_pkg::SCAN_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  xer_pkg::front_t    fq,
  input  logic               fq_valid,
  output logic               fq_pop,
  output xer_pkg::out_item_t decoded,
  output logic               empty,
  input  logic               pop
);
  import xer_pkg::*;

  localparam logic [CNT_W-1:0]   LIM_M1  = CNT_W'(SCAN_LIMIT - 1);
  localparam logic [HELD_AW-1:0] RP_LAST = HELD_AW'(SCAN_LIMIT - 1);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_REPLAY_RD = 10'b00_0000_0010,
    ST_REPLAY    = 10'b00_0000_0100,
    ST_LIM_AMP   = 10'b00_0000_1000,
    ST_UTF       = 10'b00_0001_0000,
    ST_DUMP_AMP  = 10'b00_0010_0000,
    ST_DUMP      = 10'b00_0100_0000,
    ST_DUMP_SEMI = 10'b00_1000_0000,
    ST_END       = 10'b01_0000_0000,
    ST_FIN       = 10'b10_0000_0000
  } state_t;

  state_t              state, state_next;
  logic                in_ref, in_ref_next;
  logic [CNT_W-1:0]    held_cnt, held_cnt_next;
  logic                rmode, rmode_next;
  logic [HELD_AW-1:0]  rp, rp_next;
  logic [HELD_AW-1:0]  di, di_next;
  logic [CNT_W-1:0]    dump_len, dump_len_next;
  logic                dsemi, dsemi_next;
  logic [1:0]          ui, ui_next;
  logic [2:0]          ucnt, ucnt_next;
  logic [3:0][7:0]     code, code_next;
  logic                cur_last, cur_last_next;
  logic [NAME_NUM-1:0] nm, nm_next;
  logic                first_hash, first_hash_next;
  logic                hex_mode, hex_mode_next;
  logic                num_ok, num_ok_next;
  logic                num_any, num_any_next;
  logic [31:0]         val, val_next;

  // held byte store
  logic               we;
  logic [HELD_AW-1:0] raddr;
  logic [7:0]         rd_data;

  // processing of one byte, from the front queue or from replay
  logic       proc, pdone, pgo_adv, adv;
  logic [7:0] pb;
  cls_t       pc;
  logic       name_hit, num_valid;
  logic [7:0] name_ch;
  utf_t       enc;

  // byte emit and group packing
  logic            emit_req, emit_ok, emit_fire, fin_fire, can_push;
  logic [7:0]      emit_byte;
  logic [3:0][7:0] pk;
  logic [2:0]      pk_cnt;
  logic            out_valid;

  xer_ram #(.WIDTH(8), .DEPTH(HELD_DEPTH)) u_held (
    .clk   (clk),
    .we    (we),
    .waddr (held_cnt[HELD_AW-1:0]),
    .wdata (pb),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign pb = (state == ST_IDLE) ? fq.item.text_byte : rd_data;
  assign pc = (state == ST_IDLE) ? fq.cls : classify(rd_data);
  assign proc = ((state == ST_IDLE) && fq_valid) || (state == ST_REPLAY);

  assign num_valid = first_hash && (held_cnt >= CNT_W'(2)) && num_ok && num_any;
  assign enc       = utf8_encode(val);

  always_comb begin
    name_hit = 1'b0;
    name_ch  = '0;
    for (int k = NAME_NUM - 1; k >= 0; k--) begin
      if (nm[k] && held_cnt == CNT_W'(name_len(k))) begin
        name_hit = 1'b1;
        name_ch  = name_out(k);
      end
    end
  end

  assign can_push  = !out_valid || pop;
  assign emit_ok   = (pk_cnt != 3'd4) || can_push;
  assign emit_fire = emit_req && emit_ok;
  assign fin_fire  = (state == ST_FIN) && (pk_cnt != 3'd0) && can_push;

  always_comb begin
    state_next      = state;
    in_ref_next     = in_ref;
    held_cnt_next   = held_cnt;
    rmode_next      = rmode;
    rp_next         = rp;
    di_next         = di;
    dump_len_next   = dump_len;
    dsemi_next      = dsemi;
    ui_next         = ui;
    ucnt_next       = ucnt;
    code_next       = code;
    cur_last_next   = cur_last;
    nm_next         = nm;
    first_hash_next = first_hash;
    hex_mode_next   = hex_mode;
    num_ok_next     = num_ok;
    num_any_next    = num_any;
    val_next        = val;
    emit_req        = 1'b0;
    emit_byte       = '0;
    fq_pop          = 1'b0;
    we              = 1'b0;
    raddr           = '0;
    pdone           = 1'b0;
    pgo_adv         = 1'b0;
    adv             = 1'b0;

    if (proc) begin
      if (!in_ref) begin
        pgo_adv = 1'b1;
        if (pc.is_amp) begin
          in_ref_next   = 1'b1;
          held_cnt_next = '0;
          nm_next       = '1;
          pdone         = 1'b1;
        end else begin
          emit_req  = 1'b1;
          emit_byte = pb;
          pdone     = emit_ok;
        end
      end else if (pc.is_semi) begin
        // reference closed: named, numeric or verbatim
        pdone         = 1'b1;
        in_ref_next   = 1'b0;
        held_cnt_next = '0;
        ui_next       = '0;
        if (name_hit) begin
          code_next    = '0;
          code_next[0] = name_ch;
          ucnt_next    = 3'd1;
          state_next   = ST_UTF;
        end else if (num_valid && enc.cnt != 3'd0) begin
          code_next  = enc.b;
          ucnt_next  = enc.cnt;
          state_next = ST_UTF;
        end else begin
          dump_len_next = held_cnt;
          dsemi_next    = 1'b1;
          state_next    = ST_DUMP_AMP;
        end
      end else begin
        // hold the byte and update the running decode
        pdone         = 1'b1;
        we            = 1'b1;
        held_cnt_next = held_cnt + CNT_W'(1);
        for (int k = 0; k < NAME_NUM; k++) begin
          nm_next[k] = nm[k] && (held_cnt < CNT_W'(name_len(k)))
                       && (pb == name_char(k, held_cnt[1:0]));
        end
        if (held_cnt == '0) begin
          first_hash_next = pc.is_hash;
          hex_mode_next   = 1'b0;
          num_ok_next     = 1'b1;
          num_any_next    = 1'b0;
          val_next        = '0;
        end else if (held_cnt == CNT_W'(1)) begin
          if (pc.is_x) begin
            hex_mode_next = 1'b1;
          end else if (pc.dec_ok) begin
            val_next     = {28'b0, pc.dig};
            num_any_next = 1'b1;
          end else begin
            num_ok_next = 1'b0;
          end
        end else if (hex_mode) begin
          if (pc.hex_ok) begin
            val_next     = {val[27:0], pc.dig};
            num_any_next = 1'b1;
          end else begin
            num_ok_next = 1'b0;
          end
        end else begin
          if (pc.dec_ok) begin
            val_next     = (val << 3) + (val << 1) + {28'b0, pc.dig};
            num_any_next = 1'b1;
          end else begin
            num_ok_next = 1'b0;
          end
        end
        if (held_cnt == LIM_M1) begin
          // no terminator in range: give up and replay the held bytes
          in_ref_next   = 1'b0;
          held_cnt_next = '0;
          state_next    = ST_LIM_AMP;
        end else begin
          pgo_adv = 1'b1;
        end
      end
      if (pdone && state == ST_IDLE) begin
        fq_pop        = 1'b1;
        cur_last_next = fq.item.string_end;
      end
      adv = pdone && pgo_adv;
    end

    unique case (state)
      ST_IDLE: begin
      end
      ST_REPLAY_RD: begin
        raddr      = rp;
        state_next = ST_REPLAY;
      end
      ST_REPLAY: begin
        raddr = rp;
      end
      ST_LIM_AMP: begin
        emit_req  = 1'b1;
        emit_byte = CH_AMP;
        if (emit_ok) begin
          rmode_next = 1'b1;
          rp_next    = '0;
          state_next = ST_REPLAY_RD;
        end
      end
      ST_UTF: begin
        emit_req  = 1'b1;
        emit_byte = code[ui];
        if (emit_ok) begin
          if (3'(ui) + 3'd1 == ucnt) begin
            adv = 1'b1;
          end else begin
            ui_next = ui + 2'd1;
          end
        end
      end
      ST_DUMP_AMP: begin
        emit_req  = 1'b1;
        emit_byte = CH_AMP;
        raddr     = '0;
        if (emit_ok) begin
          di_next = '0;
          if (dump_len != '0) begin
            state_next = ST_DUMP;
          end else if (dsemi) begin
            state_next = ST_DUMP_SEMI;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_DUMP: begin
        emit_req  = 1'b1;
        emit_byte = rd_data;
        raddr     = emit_ok ? di + HELD_AW'(1) : di;
        if (emit_ok) begin
          di_next = di + HELD_AW'(1);
          if (CNT_W'(di) + CNT_W'(1) == dump_len) begin
            state_next = dsemi ? ST_DUMP_SEMI : ST_FIN;
          end
        end
      end
      ST_DUMP_SEMI: begin
        emit_req  = 1'b1;
        emit_byte = CH_SEMI;
        adv       = emit_ok;
      end
      ST_END: begin
        // end of string flushes an open reference verbatim
        if (cur_last && in_ref) begin
          dump_len_next = held_cnt;
          dsemi_next    = 1'b0;
          state_next    = ST_DUMP_AMP;
        end else begin
          state_next = ST_FIN;
        end
        if (cur_last) begin
          in_ref_next   = 1'b0;
          held_cnt_next = '0;
        end
      end
      ST_FIN: begin
        if (pk_cnt == 3'd0 || can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (adv) begin
      if (rmode && rp != RP_LAST) begin
        rp_next    = rp + HELD_AW'(1);
        state_next = ST_REPLAY_RD;
      end else begin
        rmode_next = 1'b0;
        state_next = ST_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ref   <= 1'b0;
      held_cnt <= '0;
      rmode    <= 1'b0;
      cur_last <= 1'b0;
    end else begin
      state    <= state_next;
      in_ref   <= in_ref_next;
      held_cnt <= held_cnt_next;
      rmode    <= rmode_next;
      cur_last <= cur_last_next;
    end
    rp         <= rp_next;
    di         <= di_next;
    dump_len   <= dump_len_next;
    dsemi      <= dsemi_next;
    ui         <= ui_next;
    ucnt       <= ucnt_next;
    code       <= code_next;
    nm         <= nm_next;
    first_hash <= first_hash_next;
    hex_mode   <= hex_mode_next;
    num_ok     <= num_ok_next;
    num_any    <= num_any_next;
    val        <= val_next;
  end

  // group packing: a full group leaves only once the next byte shows it is not the last
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (pk_cnt == 3'd4) begin
        decoded <= '{out_byte_a: pk[0], out_byte_b: pk[1], out_byte_c: pk[2],
                     out_byte_d: pk[3], byte_count: 3'd4, run_done: 1'b0,
                     string_done: 1'b0};
        pk[0] <= emit_byte;
      end else begin
        pk[pk_cnt[1:0]] <= emit_byte;
      end
    end
    if (fin_fire) begin
      decoded <= '{out_byte_a: pk[0],
                   out_byte_b: (pk_cnt > 3'd1) ? pk[1] : 8'h00,
                   out_byte_c: (pk_cnt > 3'd2) ? pk[2] : 8'h00,
                   out_byte_d: (pk_cnt > 3'd3) ? pk[3] : 8'h00,
                   byte_count: pk_cnt, run_done: 1'b1, string_done: cur_last};
    end
    if (rst) begin
      pk_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        pk_cnt <= (pk_cnt == 3'd4) ? 3'd1 : pk_cnt + 3'd1;
      end else if (fin_fire) begin
        pk_cnt <= '0;
      end
      if ((emit_fire && pk_cnt == 3'd4) || fin_fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;
endmodule

[hdl/xer_entity_reference_decoder.sv]
// top level of the xml entity and character reference decoder
// a plain byte is held in a front queue slot, then in the packing group, before it reaches the result register
// items are handled one at a time: a plain or held byte passes the idle, end and fin states;
//   a ';' closing a reference emits its bytes first, and a scan-limit replay rereads held bytes
// reset: synchronous, clears control state only; the held-byte ram is not cleared and
//   only entries written since the current reference opened are ever read
module xml_entity_reference_decoder #(
  parameter int SCAN_LIMIT = xer_pkg::SCAN_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  xer_pkg::in_item_t  text,
  input  logic               push,
  output logic               full,
  output xer_pkg::out_item_t decoded,
  output logic               empty,
  input  logic               pop
);
  import xer_pkg::*;

  front_t fq;
  logic   fq_valid;
  logic   fq_pop;

  // front: input item queue with byte classification
  xer_front u_front (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .push     (push),
    .full     (full),
    .fq       (fq),
    .fq_valid (fq_valid),
    .fq_pop   (fq_pop)
  );

  // back: reference decode, replay and group packing into the result register
  xer_back #(.SCAN_LIMIT(SCAN_LIMIT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .fq       (fq),
    .fq_valid (fq_valid),
    .fq_pop   (fq_pop),
    .decoded  (decoded),
    .empty    (empty),
    .pop      (pop)
  );
endmodule
